// ===== rtl/irpe_pkg.sv =====
// shared types, phase codes, register indexes and frame constants
// for the ir frame pulse encoder; no dependencies
`default_nettype none

package irpe_pkg;

   localparam int FRAME_BYTES = 9;
   localparam int FRAME_BITS  = FRAME_BYTES * 8;
   localparam int LEN_W       = 16;
   localparam int POS_W       = 7;
   localparam int IDX_W       = 3;

   typedef logic [LEN_W-1:0]      len_type;
   typedef logic [POS_W-1:0]      pos_type;
   typedef logic [FRAME_BITS-1:0] frame_type;
   typedef logic [2:0]            phase_type;

   // envelope phases
   localparam phase_type PH_IDLE       = 3'd0;
   localparam phase_type PH_HDR_MARK   = 3'd1;
   localparam phase_type PH_HDR_SPACE  = 3'd2;
   localparam phase_type PH_BIT_MARK   = 3'd3;
   localparam phase_type PH_BIT_SPACE  = 3'd4;
   localparam phase_type PH_FOOT_MARK  = 3'd5;
   localparam phase_type PH_GAP        = 3'd6;

   // register indexes
   localparam logic [IDX_W-1:0] REG_HEADER_MARK  = 3'd0;
   localparam logic [IDX_W-1:0] REG_HEADER_SPACE = 3'd1;
   localparam logic [IDX_W-1:0] REG_BIT_MARK     = 3'd2;
   localparam logic [IDX_W-1:0] REG_ONE_SPACE    = 3'd3;
   localparam logic [IDX_W-1:0] REG_ZERO_SPACE   = 3'd4;
   localparam logic [IDX_W-1:0] REG_GAP_SPACE    = 3'd5;

   localparam len_type RST_HEADER_MARK  = 16'd9035;
   localparam len_type RST_HEADER_SPACE = 16'd4517;
   localparam len_type RST_BIT_MARK     = 16'd667;
   localparam len_type RST_ONE_SPACE    = 16'd517;
   localparam len_type RST_ZERO_SPACE   = 16'd1543;
   localparam len_type RST_GAP_SPACE    = 16'd4517;

   // climate modes
   localparam logic [1:0] MODE_OFF  = 2'd0;
   localparam logic [1:0] MODE_AUTO = 2'd1;
   localparam logic [1:0] MODE_COOL = 2'd2;
   localparam logic [1:0] MODE_HEAT = 2'd3;

   localparam logic [7:0] TEMP_MIN = 8'd16;
   localparam logic [7:0] TEMP_MAX = 8'd30;

   // a zero length still lasts one tick
   function automatic len_type len_fix(input len_type v);
      return (v == '0) ? len_type'(1) : v;
   endfunction

   // temperature byte, indexed by degrees above the minimum
   function automatic logic [7:0] temp_byte(input logic [3:0] idx);
      logic [7:0] b;
      case (idx)
         4'd0:    b = 8'h64;
         4'd1:    b = 8'hA4;
         4'd2:    b = 8'h24;
         4'd3:    b = 8'hC4;
         4'd4:    b = 8'h44;
         4'd5:    b = 8'h84;
         4'd6:    b = 8'h04;
         4'd7:    b = 8'hF8;
         4'd8:    b = 8'h78;
         4'd9:    b = 8'hB8;
         4'd10:   b = 8'h38;
         4'd11:   b = 8'hD8;
         4'd12:   b = 8'h58;
         4'd13:   b = 8'h98;
         4'd14:   b = 8'h18;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ac_ir_frame_pulse_encoder_unit.sv =====
// top level of the ir frame pulse-distance envelope encoder
// depends on irpe_pkg and irpe_frame_build
`default_nettype none

// usage
// - req channel: one item per transfer; action 1 starts a frame from mode and
//   target_celsius, action 0 is one microsecond tick of the envelope
// - rsp channel: exactly one result per request transfer, carrying the level
//   driven in that microsecond, the busy flag and the end-of-frame flag
// - csr port: six 16-bit timing registers, written with csr_write_en; an index
//   past the last register is dropped; write only while no frame is running
// - a result is registered and appears in the cycle after its request transfer
// - throughput: one request per cycle unless stalled; the whole step (counter
//   decrement, phase advance) is one logic pass from state to result registers
// - a stalled rsp side holds its result; req_ready stays high as long as the
//   result register is empty or being drained in the same cycle
// - reset: phase idle, counters zero, timing registers at their defaults,
//   result register empty
// - a send command while a frame is running is dropped, its result shows busy
`default_nettype none

module ac_ir_frame_pulse_encoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic        req_action,
   input  wire logic [1:0]  req_mode,
   input  wire logic [7:0]  req_target_celsius,

   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic        rsp_ir_level,
   output      logic        rsp_busy_res,
   output      logic        rsp_frame_done,

   input  wire logic        csr_write_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   // timing registers
   irpe_pkg::len_type hdr_mark_ff, hdr_space_ff, bit_mark_ff;
   irpe_pkg::len_type one_space_ff, zero_space_ff, gap_space_ff;

   // envelope state; the frame shifts left so the current bit is always the msb
   irpe_pkg::frame_type frame_ff, frame_in;
   irpe_pkg::pos_type   bit_pos_ff, bit_pos_in;
   irpe_pkg::phase_type phase_ff, phase_in;
   irpe_pkg::len_type   tick_ff, tick_in;

   // result register
   logic rsp_valid_ff;
   logic level_ff, level_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;

   irpe_pkg::frame_type new_frame;
   irpe_pkg::phase_type phase_cur;
   irpe_pkg::len_type   tick_dec;
   irpe_pkg::pos_type   bit_pos_inc;
   logic                req_xfer;
   logic                cur_mark;

   irpe_frame_build u_frame_build (
      .mode           (req_mode),
      .target_celsius (req_target_celsius),
      .frame          (new_frame)
   );

   // output register decouples the two sides
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ir_level   = level_ff;
   assign rsp_busy_res   = busy_ff;
   assign rsp_frame_done = done_ff;

   // an unused phase code counts as idle
   assign phase_cur   = (phase_ff > irpe_pkg::PH_GAP) ? irpe_pkg::PH_IDLE : phase_ff;
   assign cur_mark    = (phase_cur == irpe_pkg::PH_HDR_MARK) ||
                        (phase_cur == irpe_pkg::PH_BIT_MARK) ||
                        (phase_cur == irpe_pkg::PH_FOOT_MARK);
   assign tick_dec    = (tick_ff != '0) ? tick_ff - irpe_pkg::len_type'(1) : tick_ff;
   assign bit_pos_inc = bit_pos_ff + irpe_pkg::pos_type'(1);

   always_comb begin
      frame_in   = frame_ff;
      bit_pos_in = bit_pos_ff;
      phase_in   = phase_cur;
      tick_in    = tick_ff;
      level_in   = 1'b0;
      busy_in    = 1'b0;
      done_in    = 1'b0;

      if (req_action) begin
         busy_in = 1'b1;
         if (phase_cur == irpe_pkg::PH_IDLE) begin
            // start a frame; the header mark is what the next tick drives
            frame_in   = new_frame;
            bit_pos_in = '0;
            phase_in   = irpe_pkg::PH_HDR_MARK;
            tick_in    = irpe_pkg::len_fix(hdr_mark_ff);
            level_in   = 1'b1;
         end else begin
            level_in = cur_mark;
         end
      end else if (phase_cur != irpe_pkg::PH_IDLE) begin
         level_in = cur_mark;
         busy_in  = 1'b1;
         tick_in  = tick_dec;
         if (tick_dec == '0) begin
            case (phase_cur)
               irpe_pkg::PH_HDR_MARK: begin
                  phase_in = irpe_pkg::PH_HDR_SPACE;
                  tick_in  = irpe_pkg::len_fix(hdr_space_ff);
               end
               irpe_pkg::PH_HDR_SPACE: begin
                  phase_in = irpe_pkg::PH_BIT_MARK;
                  tick_in  = irpe_pkg::len_fix(bit_mark_ff);
               end
               irpe_pkg::PH_BIT_MARK: begin
                  phase_in = irpe_pkg::PH_BIT_SPACE;
                  tick_in  = frame_ff[irpe_pkg::FRAME_BITS-1] ?
                             irpe_pkg::len_fix(one_space_ff) :
                             irpe_pkg::len_fix(zero_space_ff);
               end
               irpe_pkg::PH_BIT_SPACE: begin
                  bit_pos_in = bit_pos_inc;
                  frame_in   = {frame_ff[irpe_pkg::FRAME_BITS-2:0], 1'b0};
                  if (bit_pos_inc >= irpe_pkg::pos_type'(irpe_pkg::FRAME_BITS)) begin
                     phase_in = irpe_pkg::PH_FOOT_MARK;
                  end else begin
                     phase_in = irpe_pkg::PH_BIT_MARK;
                  end
                  tick_in = irpe_pkg::len_fix(bit_mark_ff);
               end
               irpe_pkg::PH_FOOT_MARK: begin
                  phase_in = irpe_pkg::PH_GAP;
                  tick_in  = irpe_pkg::len_fix(gap_space_ff);
               end
               default: begin
                  // end of the gap closes the frame
                  phase_in   = irpe_pkg::PH_IDLE;
                  tick_in    = '0;
                  bit_pos_in = '0;
                  done_in    = 1'b1;
               end
            endcase
         end
      end
   end

   // envelope state
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff   <= '0;
         bit_pos_ff <= '0;
         phase_ff   <= irpe_pkg::PH_IDLE;
         tick_ff    <= '0;
      end else if (req_xfer) begin
         frame_ff   <= frame_in;
         bit_pos_ff <= bit_pos_in;
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         level_ff <= level_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   // timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_mark_ff   <= irpe_pkg::RST_HEADER_MARK;
         hdr_space_ff  <= irpe_pkg::RST_HEADER_SPACE;
         bit_mark_ff   <= irpe_pkg::RST_BIT_MARK;
         one_space_ff  <= irpe_pkg::RST_ONE_SPACE;
         zero_space_ff <= irpe_pkg::RST_ZERO_SPACE;
         gap_space_ff  <= irpe_pkg::RST_GAP_SPACE;
      end else if (csr_write_en) begin
         case (csr_index)
            irpe_pkg::REG_HEADER_MARK:  hdr_mark_ff   <= csr_wdata;
            irpe_pkg::REG_HEADER_SPACE: hdr_space_ff  <= csr_wdata;
            irpe_pkg::REG_BIT_MARK:     bit_mark_ff   <= csr_wdata;
            irpe_pkg::REG_ONE_SPACE:    one_space_ff  <= csr_wdata;
            irpe_pkg::REG_ZERO_SPACE:   zero_space_ff <= csr_wdata;
            irpe_pkg::REG_GAP_SPACE:    gap_space_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // checks

   // a running phase always has ticks left
   a_tick_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != irpe_pkg::PH_IDLE) |-> (tick_ff != '0))
      else $error("running phase with empty tick counter");

   // the bit index never runs past the frame
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      bit_pos_ff <= irpe_pkg::pos_type'(irpe_pkg::FRAME_BITS))
      else $error("bit position past end of frame");

   // a command taken while idle starts with the header mark
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_action && phase_ff == irpe_pkg::PH_IDLE)
      |=> (phase_ff == irpe_pkg::PH_HDR_MARK && rsp_valid && rsp_ir_level))
      else $error("command in idle did not start a frame");

   // end of frame is reported only on a busy result and leaves the block idle
   a_done: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && done_in) |=> (rsp_busy_res && phase_ff == irpe_pkg::PH_IDLE))
      else $error("frame end without return to idle");

   // a tick while idle stays idle with a quiet result
   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !req_action && phase_ff == irpe_pkg::PH_IDLE)
      |=> (phase_ff == irpe_pkg::PH_IDLE && !rsp_ir_level && !rsp_busy_res))
      else $error("idle tick changed state");

endmodule

`default_nettype wire

// ===== rtl/irpe_frame_build.sv =====
// builds the nine-byte frame from mode and target temperature
// depends on irpe_pkg
`default_nettype none

module irpe_frame_build (
   input  wire logic [1:0]         mode,
   input  wire logic [7:0]         target_celsius,
   output irpe_pkg::frame_type     frame
);

   logic [7:0] b0;
   logic [7:0] b5;
   logic [7:0] t_clamp;
   logic [7:0] t_off;

   always_comb begin
      b0 = 8'h0E;
      b5 = 8'h1F;
      case (mode)
         irpe_pkg::MODE_AUTO: begin
            b0 = b0 | 8'hE0;
         end
         irpe_pkg::MODE_COOL: begin
            b0 = b0 | 8'hE0;
            b5 = b5 | 8'h80;
         end
         irpe_pkg::MODE_HEAT: begin
            b0 = b0 | 8'h20;
         end
         default: begin
            b0 = b0 | 8'hF0;
            b5 = b5 | 8'h80;
         end
      endcase

      // clamp to the supported range
      if (target_celsius < irpe_pkg::TEMP_MIN) begin
         t_clamp = irpe_pkg::TEMP_MIN;
      end else if (target_celsius > irpe_pkg::TEMP_MAX) begin
         t_clamp = irpe_pkg::TEMP_MAX;
      end else begin
         t_clamp = target_celsius;
      end
      t_off = t_clamp - irpe_pkg::TEMP_MIN;

      // byte 0 sits at the top, sent first
      frame = {b0,
               8'h03 | irpe_pkg::temp_byte(t_off[3:0]),
               8'hFF,
               8'hFF,
               8'h03,
               b5,
               8'hFF,
               8'hFF,
               8'hCF};
   end

endmodule

`default_nettype wire
